FILE: src/wfea_pkg.sv
package wfea_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_NO_SPACE = 2'd1;
  localparam status_t ST_NOT_LIVE = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

endpackage

FILE: src/worst_fit_extent_allocator_unit.sv
// Allocate keeps busy high for one pass of the extent table through its single read port to
// find the largest extent. A valid free also makes one pass of the table, then steps through
// SH_RD and SH_WR for each entry moved when an extent is inserted or absorbed; a rejected
// free ends after the live-block lookup. One request at a time; busy stays high until the
// result beat on done. After rst, a clearing pass over all HEAP_BYTES / 8 entries empties the
// live-block table with busy high. The receiver cannot stall; each result shows for one cycle.
module worst_fit_extent_allocator_unit #(
  parameter int HEAP_BYTES   = 4096,
  parameter int MAX_EXTENTS  = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type,
  input  logic [11:0]            alloc_size,
  input  logic [11:0]            block_addr,
  output logic                   done,
  output wfea_pkg::status_t      status,
  output logic [11:0]            block_offset
);
  import wfea_pkg::*;

  localparam int SW = (($clog2(HEAP_BYTES) > 12) ? $clog2(HEAP_BYTES) : 12) + 2;
  localparam int LD = HEAP_BYTES / 8;
  localparam int LW = $clog2(LD);
  localparam int EW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);

  typedef enum logic [3:0] {
    CLEAR, IDLE, A_SCAN, A_CALC, F_LIVE, F_CHK, F_SCAN, F_DEC, SH_RD, SH_WR, SH_FIN
  } state_t;

  state_t        state;
  logic [LW-1:0] clr;
  logic [CW-1:0] cnt;
  logic [CW-1:0] ptr;
  logic [CW-1:0] pidx;
  logic          pvld;
  logic [SW-1:0] need;
  logic [SW-1:0] addr;
  logic [SW-1:0] total;
  logic [EW-1:0] best;
  logic [SW-1:0] bs, bf;
  logic          have_left, have_nx;
  logic [EW-1:0] left, nx;
  logic [SW-1:0] ls, lf, ns, nf;
  logic          sh_up;

  logic [SW-1:0] live_mem [LD];
  logic [SW-1:0] live_rd;
  logic          live_we;
  logic [LW-1:0] live_waddr;
  logic [SW-1:0] live_wdata;
  logic [SW-1:0] idx_ext;

  logic [EW-1:0] e_raddr, e_waddr;
  logic          e_we_start, e_we_free;
  logic [SW-1:0] e_wstart, e_wfree, rd_start, rd_free;

  logic [SW-1:0] cost, newfree, off;
  logic          fit, off_ok;
  logic [SW-1:0] lend, nlf, nlf_abs;
  logic          lmerge, absorb, rmerge, full;

  assign busy    = (state != IDLE);
  assign idx_ext = addr >> 3;

  assign cost    = need + HDR;
  assign fit     = (cost <= bf);
  assign newfree = bf - cost;
  assign off     = bs + HDR + newfree;
  assign off_ok  = (off[2:0] == 3'd0) && ((off >> 3) < SW'(LD));

  assign lend    = ls + HDR + lf;
  assign lmerge  = have_left && (lend == addr);
  assign nlf     = lf + total;
  assign absorb  = have_nx && (ns == ls + HDR + nlf);
  assign nlf_abs = nlf + nf + HDR;
  assign rmerge  = have_nx && (addr + total == ns);
  assign full    = (cnt >= CW'(MAX_EXTENTS));

  wfea_ext_ram #(.EW(EW), .SW(SW)) u_ext (
    .clk      (clk),
    .raddr    (e_raddr),
    .rd_start (rd_start),
    .rd_free  (rd_free),
    .waddr    (e_waddr),
    .we_start (e_we_start),
    .we_free  (e_we_free),
    .wr_start (e_wstart),
    .wr_free  (e_wfree)
  );

  assign e_raddr = (state == SH_RD && sh_up) ? EW'(ptr - CW'(1)) : ptr[EW-1:0];

  always_comb begin
    e_we_start = 1'b0;
    e_we_free  = 1'b0;
    e_waddr    = ptr[EW-1:0];
    e_wstart   = rd_start;
    e_wfree    = rd_free;
    live_we    = 1'b0;
    live_waddr = idx_ext[LW-1:0];
    live_wdata = '0;
    case (state)
      CLEAR: begin
        live_we    = 1'b1;
        live_waddr = clr;
        if (clr == '0) begin
          e_we_start = 1'b1;
          e_we_free  = 1'b1;
          e_waddr    = '0;
          e_wstart   = '0;
          e_wfree    = SW'(HEAP_BYTES - HEADER_BYTES);
        end
      end
      A_CALC: begin
        if (cnt != '0 && fit && off_ok) begin
          e_we_free  = 1'b1;
          e_waddr    = best;
          e_wfree    = newfree;
          live_we    = 1'b1;
          live_waddr = off[LW+2:3];
          live_wdata = cost;
        end
      end
      F_DEC: begin
        if (lmerge) begin
          e_we_free = 1'b1;
          e_waddr   = left;
          e_wfree   = absorb ? nlf_abs : nlf;
          live_we   = 1'b1;
        end else if (rmerge) begin
          e_we_start = 1'b1;
          e_we_free  = 1'b1;
          e_waddr    = nx;
          e_wstart   = addr;
          e_wfree    = nf + total;
          live_we    = 1'b1;
        end else if (!full) begin
          live_we = 1'b1;
        end
      end
      SH_WR: begin
        e_we_start = 1'b1;
        e_we_free  = 1'b1;
        e_waddr    = sh_up ? ptr[EW-1:0] : EW'(ptr - CW'(1));
      end
      SH_FIN: begin
        if (sh_up) begin
          e_we_start = 1'b1;
          e_we_free  = 1'b1;
          e_waddr    = nx;
          e_wstart   = addr;
          e_wfree    = total - HDR;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
    live_rd <= live_mem[idx_ext[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CLEAR;
      clr          <= '0;
      cnt          <= CW'(1);
      done         <= 1'b0;
      status       <= ST_DONE;
      block_offset <= '0;
      pvld         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        CLEAR: begin
          clr <= clr + LW'(1);
          if (clr == LW'(LD - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (start) begin
            need      <= (SW'(alloc_size) + SW'(7)) & ~SW'(7);
            addr      <= SW'(block_addr);
            ptr       <= '0;
            pvld      <= 1'b0;
            have_left <= 1'b0;
            have_nx   <= 1'b0;
            state     <= (req_type == REQ_FREE) ? F_LIVE : A_SCAN;
          end
        end
        A_SCAN: begin
          pvld <= (ptr < cnt);
          pidx <= ptr;
          if (ptr < cnt) begin
            ptr <= ptr + CW'(1);
          end
          if (pvld && (pidx == '0 || rd_free > bf)) begin
            best <= pidx[EW-1:0];
            bs   <= rd_start;
            bf   <= rd_free;
          end
          if (!pvld && ptr >= cnt) begin
            state <= A_CALC;
          end
        end
        A_CALC: begin
          done  <= 1'b1;
          state <= IDLE;
          if (cnt != '0 && fit && off_ok) begin
            status       <= ST_DONE;
            block_offset <= off[11:0];
          end else begin
            status       <= ST_NO_SPACE;
            block_offset <= '0;
          end
        end
        F_LIVE: begin
          state <= F_CHK;
        end
        F_CHK: begin
          total <= live_rd;
          if (addr[2:0] != 3'd0 || idx_ext >= SW'(LD) || live_rd == '0) begin
            done         <= 1'b1;
            status       <= ST_NOT_LIVE;
            block_offset <= '0;
            state        <= IDLE;
          end else begin
            state <= F_SCAN;
          end
        end
        F_SCAN: begin
          pvld <= (ptr < cnt);
          pidx <= ptr;
          if (ptr < cnt) begin
            ptr <= ptr + CW'(1);
          end
          if (pvld) begin
            if (rd_start < addr) begin
              have_left <= 1'b1;
              left      <= pidx[EW-1:0];
              ls        <= rd_start;
              lf        <= rd_free;
            end else if (!have_nx) begin
              have_nx <= 1'b1;
              nx      <= pidx[EW-1:0];
              ns      <= rd_start;
              nf      <= rd_free;
            end
          end
          if (!pvld && ptr >= cnt) begin
            state <= F_DEC;
          end
        end
        F_DEC: begin
          block_offset <= '0;
          if (lmerge && absorb) begin
            // The next extent now touches the grown left one; close the gap in the table.
            sh_up <= 1'b0;
            ptr   <= CW'(nx) + CW'(1);
            state <= SH_RD;
          end else if (lmerge || rmerge) begin
            done   <= 1'b1;
            status <= ST_DONE;
            state  <= IDLE;
          end else if (full) begin
            done   <= 1'b1;
            status <= ST_NO_SPACE;
            state  <= IDLE;
          end else begin
            sh_up <= 1'b1;
            ptr   <= cnt;
            if (!have_nx) begin
              nx <= cnt[EW-1:0];
            end
            state <= SH_RD;
          end
        end
        SH_RD: begin
          if (sh_up ? (ptr == CW'(nx)) : (ptr >= cnt)) begin
            state <= SH_FIN;
          end else begin
            state <= SH_WR;
          end
        end
        SH_WR: begin
          ptr   <= sh_up ? ptr - CW'(1) : ptr + CW'(1);
          state <= SH_RD;
        end
        SH_FIN: begin
          cnt    <= sh_up ? cnt + CW'(1) : cnt - CW'(1);
          done   <= 1'b1;
          status <= ST_DONE;
          state  <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while a request is still in work");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("accepted request did not raise busy");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_DONE || status == ST_NO_SPACE || status == ST_NOT_LIVE))
    else $error("undefined status code");
  a_fail_offset: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_DONE |-> block_offset == '0)
    else $error("failed request returned an offset");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_EXTENTS))
    else $error("extent count beyond table size");

endmodule

FILE: src/wfea_ext_ram.sv
module wfea_ext_ram #(
  parameter int EW = 6,
  parameter int SW = 14
) (
  input  logic          clk,
  input  logic [EW-1:0] raddr,
  output logic [SW-1:0] rd_start,
  output logic [SW-1:0] rd_free,
  input  logic [EW-1:0] waddr,
  input  logic          we_start,
  input  logic          we_free,
  input  logic [SW-1:0] wr_start,
  input  logic [SW-1:0] wr_free
);
  localparam int DEPTH = 1 << EW;

  logic [SW-1:0] start_mem [DEPTH];
  logic [SW-1:0] free_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we_start) begin
      start_mem[waddr] <= wr_start;
    end
    if (we_free) begin
      free_mem[waddr] <= wr_free;
    end
    rd_start <= start_mem[raddr];
    rd_free  <= free_mem[raddr];
  end

endmodule
